/* rtl/rtt_pkg.sv */
// Shared types for the region entry trigger table.
// Request codes, table entry layout and queued request layout.
// No dependencies.
package rtt_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } rtt_op_t;

  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_SLAB   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [23:0] first_x;
    logic [23:0] first_y;
    logic [23:0] first_z;
    logic [23:0] end_x;
    logic [23:0] end_y;
    logic [22:0] reach;
    logic [22:0] height;
  } rtt_entry_t;

  // One queued request; a sample carries its position in first_x/y/z.
  typedef struct packed {
    rtt_op_t    op;
    logic [3:0] idx;
    rtt_entry_t ent;
  } rtt_req_t;

endpackage

/* rtl/rtt_front.sv */
// Front end: accepts input requests, decodes the operation, and holds
// them in a two-deep queue for the scan engine. Uses rtt_pkg.
module rtt_front
  import rtt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_region_index,
  input  logic               in_region_kind,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  input  logic signed [23:0] in_coord_z,
  input  logic signed [23:0] in_end_x,
  input  logic signed [23:0] in_end_y,
  input  logic [22:0]        in_reach,
  input  logic [22:0]        in_slab_height,
  output logic               q_valid,
  output rtt_req_t           q_req,
  input  logic               q_pop
);

  rtt_req_t   q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  rtt_req_t   req;

  always_comb begin
    req.idx         = in_region_index;
    req.ent.kind    = in_region_kind;
    req.ent.first_x = in_coord_x;
    req.ent.first_y = in_coord_y;
    req.ent.first_z = in_coord_z;
    req.ent.end_x   = in_end_x;
    req.ent.end_y   = in_end_y;
    req.ent.reach   = in_reach;
    req.ent.height  = in_slab_height;
    unique case (in_operation)
      OP_SAMPLE: req.op = OP_SAMPLE;
      OP_WRITE:  req.op = OP_WRITE;
      OP_CLEAR:  req.op = OP_CLEAR;
      default:   req.op = OP_NOP;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_req    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0)
    else $error("pop from empty queue");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !q_pop) |=> count_r == 2'd2)
    else $error("full queue lost a request");

endmodule

/* rtl/rtt_scan.sv */
// Back end: region table memory, one-shot latches, scan sequencer with a
// shared 26x26 multiplier, and the result register. Uses rtt_pkg.
module rtt_scan
  import rtt_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] active_regions,
  input  logic       q_valid,
  input  rtt_req_t   q_req,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_fired,
  output logic [3:0] out_fired_region
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [4:0] LAST_SPHERE = 5'd6;
  localparam logic [4:0] LAST_SLAB   = 5'd16;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_STEP, S_DONE} state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         lim_r;
  logic [CNT_W-1:0]         lim;
  logic [IDX_W-1:0]         ci;
  logic [4:0]               step_r;
  logic [MAX_REGIONS-1:0]   latched_r;
  logic                     res_fired_r;
  logic [3:0]               res_idx_r;
  logic                     out_valid_r;
  logic                     out_fired_r;
  logic [3:0]               out_idx_r;

  rtt_entry_t               mem [MAX_REGIONS];
  rtt_entry_t               rd_r;
  logic                     mem_we;
  logic                     wr_ok;
  logic [IDX_W-1:0]         waddr;

  logic signed [23:0]       px_r, py_r, pz_r;
  logic                     kind_r;
  logic                     zok_r;
  logic signed [24:0]       e1x_r, e1y_r, e2x_r, e2y_r, dz_r;
  logic [22:0]              r_r;
  logic signed [24:0]       top_z;

  logic signed [25:0]       mul_a, mul_b;
  logic signed [51:0]       prod_r;
  logic [4:0]               tag_r;
  logic signed [51:0]       acc0_r, acc1_r, acc2_r;
  logic [45:0]              r2_r;
  logic [99:0]              acc_a_r, acc_b_r;
  logic [51:0]              neg_cr;
  logic [49:0]              c_mag;
  logic [49:0]              d_val;
  logic [49:0]              p_u;
  logic [4:0]               last_step;
  logic                     sph_hit, slab_hit, hit;

  assign ci     = cnt_r[IDX_W-1:0];
  assign lim    = (32'(active_regions) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
                                                      : CNT_W'(active_regions);
  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign wr_ok  = (32'(q_req.idx) < MAX_REGIONS);
  assign waddr  = IDX_W'(q_req.idx);
  assign mem_we = q_pop && (q_req.op == OP_WRITE) && wr_ok;

  // table memory, registered read at the scan index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= q_req.ent;
    end
    rd_r <= mem[ci];
  end

  // operands for the shared multiplier
  assign neg_cr = -acc2_r;
  assign c_mag  = acc2_r[51] ? neg_cr[49:0] : acc2_r[49:0];
  assign d_val  = acc0_r[49:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (kind_r == KIND_SLAB) begin
      case (step_r)
        5'd1:  begin mul_a = {e1x_r[24], e1x_r}; mul_b = {e1x_r[24], e1x_r}; end
        5'd2:  begin mul_a = {e1y_r[24], e1y_r}; mul_b = {e1y_r[24], e1y_r}; end
        5'd3:  begin mul_a = {e1x_r[24], e1x_r}; mul_b = {e2x_r[24], e2x_r}; end
        5'd4:  begin mul_a = {e1y_r[24], e1y_r}; mul_b = {e2y_r[24], e2y_r}; end
        5'd5:  begin mul_a = {e1x_r[24], e1x_r}; mul_b = {e2y_r[24], e2y_r}; end
        5'd6:  begin mul_a = {e1y_r[24], e1y_r}; mul_b = {e2x_r[24], e2x_r}; end
        5'd7:  begin mul_a = {3'b0, r_r}; mul_b = {3'b0, r_r}; end
        5'd8:  begin mul_a = {1'b0, c_mag[49:25]}; mul_b = {1'b0, c_mag[49:25]}; end
        5'd9:  begin mul_a = {1'b0, c_mag[49:25]}; mul_b = {1'b0, c_mag[24:0]}; end
        5'd10: begin mul_a = {1'b0, c_mag[24:0]}; mul_b = {1'b0, c_mag[24:0]}; end
        5'd11: begin mul_a = {5'b0, r2_r[45:25]}; mul_b = {1'b0, d_val[49:25]}; end
        5'd12: begin mul_a = {5'b0, r2_r[45:25]}; mul_b = {1'b0, d_val[24:0]}; end
        5'd13: begin mul_a = {1'b0, r2_r[24:0]}; mul_b = {1'b0, d_val[49:25]}; end
        5'd14: begin mul_a = {1'b0, r2_r[24:0]}; mul_b = {1'b0, d_val[24:0]}; end
        default: ;
      endcase
    end else begin
      case (step_r)
        5'd1: begin mul_a = {e2x_r[24], e2x_r}; mul_b = {e2x_r[24], e2x_r}; end
        5'd2: begin mul_a = {e2y_r[24], e2y_r}; mul_b = {e2y_r[24], e2y_r}; end
        5'd3: begin mul_a = {dz_r[24], dz_r}; mul_b = {dz_r[24], dz_r}; end
        5'd4: begin mul_a = {3'b0, r_r}; mul_b = {3'b0, r_r}; end
        default: ;
      endcase
    end
  end

  assign top_z = $signed({rd_r.first_z[23], rd_r.first_z}) +
                 $signed({2'b0, rd_r.height});
  assign p_u   = prod_r[49:0];

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    tag_r  <= (state_r == S_STEP) ? step_r : 5'd0;
    if (q_pop && q_req.op == OP_SAMPLE) begin
      px_r <= q_req.ent.first_x;
      py_r <= q_req.ent.first_y;
      pz_r <= q_req.ent.first_z;
    end
    if (state_r == S_RD) begin
      kind_r  <= rd_r.kind;
      r_r     <= rd_r.reach;
      e1x_r   <= $signed({rd_r.end_x[23], rd_r.end_x}) -
                 $signed({rd_r.first_x[23], rd_r.first_x});
      e1y_r   <= $signed({rd_r.end_y[23], rd_r.end_y}) -
                 $signed({rd_r.first_y[23], rd_r.first_y});
      e2x_r   <= $signed({px_r[23], px_r}) - $signed({rd_r.first_x[23], rd_r.first_x});
      e2y_r   <= $signed({py_r[23], py_r}) - $signed({rd_r.first_y[23], rd_r.first_y});
      dz_r    <= $signed({pz_r[23], pz_r}) - $signed({rd_r.first_z[23], rd_r.first_z});
      zok_r   <= ($signed(pz_r) > $signed(rd_r.first_z)) &&
                 ($signed({pz_r[23], pz_r}) < top_z);
      acc0_r  <= '0;
      acc1_r  <= '0;
      acc2_r  <= '0;
      r2_r    <= '0;
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (kind_r == KIND_SLAB) begin
      case (tag_r)
        5'd1, 5'd2: acc0_r  <= acc0_r + prod_r;
        5'd3, 5'd4: acc1_r  <= acc1_r + prod_r;
        5'd5:       acc2_r  <= acc2_r + prod_r;
        5'd6:       acc2_r  <= acc2_r - prod_r;
        5'd7:       r2_r    <= prod_r[45:0];
        5'd8:       acc_a_r <= acc_a_r + (100'(p_u) << 50);
        5'd9:       acc_a_r <= acc_a_r + (100'(p_u) << 26);
        5'd10:      acc_a_r <= acc_a_r + 100'(p_u);
        5'd11:      acc_b_r <= acc_b_r + (100'(p_u) << 50);
        5'd12, 5'd13: acc_b_r <= acc_b_r + (100'(p_u) << 25);
        5'd14:      acc_b_r <= acc_b_r + 100'(p_u);
        default: ;
      endcase
    end else begin
      case (tag_r)
        5'd1, 5'd2, 5'd3: acc0_r <= acc0_r + prod_r;
        5'd4:             r2_r   <= prod_r[45:0];
        default: ;
      endcase
    end
  end

  // containment decisions; a zero-length segment never triggers
  assign sph_hit  = acc0_r[51:0] < 52'(r2_r);
  assign slab_hit = zok_r && (acc0_r != '0) && !acc1_r[51] &&
                    (acc1_r <= acc0_r) && (acc_a_r < acc_b_r);
  assign hit       = (kind_r == KIND_SLAB) ? slab_hit : sph_hit;
  assign last_step = (kind_r == KIND_SLAB) ? LAST_SLAB : LAST_SPHERE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lim_r       <= '0;
      step_r      <= '0;
      latched_r   <= '0;
      res_fired_r <= 1'b0;
      res_idx_r   <= '0;
      out_valid_r <= 1'b0;
      out_fired_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      // S_DONE drives out_valid_r itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            res_fired_r <= 1'b0;
            res_idx_r   <= '0;
            unique case (q_req.op)
              OP_WRITE: begin
                if (wr_ok) begin
                  latched_r[waddr] <= 1'b0;
                end
                state_r <= S_DONE;
              end
              OP_CLEAR: begin
                latched_r <= '0;
                state_r   <= S_DONE;
              end
              OP_SAMPLE: begin
                cnt_r   <= '0;
                lim_r   <= lim;
                state_r <= S_SCAN;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (cnt_r == lim_r) begin
            state_r <= S_DONE;
          end else if (latched_r[ci]) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          step_r  <= 5'd1;
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (step_r == last_step) begin
            if (hit) begin
              latched_r[ci] <= 1'b1;
              res_fired_r   <= 1'b1;
              res_idx_r     <= 4'(ci);
              state_r       <= S_DONE;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_SCAN;
            end
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_fired_r <= res_fired_r;
            out_idx_r   <= res_idx_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_fired_region = out_idx_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("request popped while busy");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> (step_r != 5'd0 && step_r <= LAST_SLAB))
    else $error("step counter out of range");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r <= lim_r)
    else $error("scan ran past active count");
  a_fire_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_fired_r) |-> latched_r[IDX_W'(res_idx_r)])
    else $error("fired region not latched");
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_fired_r) |-> out_idx_r == 4'd0)
    else $error("miss carries a region index");

endmodule

/* rtl/region_entry_trigger_table.sv */
// Top level of the region entry trigger table.
// Holds the active count register and joins rtt_front and rtt_scan; uses rtt_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): one request per handshake. Operation
//    0 samples a position, 1 writes table entry in_region_index and clears its
//    latch, 2 clears all latches, 3 does nothing.
//  - Output channel (out_valid/out_ready): exactly one result per request.
//    out_fired is 1 when a sample entered an unlatched region; out_fired_region
//    then names it, else both read zero.
//  - cfg_wr_en/cfg_wr_data set the number of entries scanned; write it only
//    while the block is idle.
//  - A sample checks one entry at a time on a single shared 26x26 multiplier;
//    a latched entry is skipped, and a slab takes more multiplier steps than a
//    sphere.
//  - Queueing: the scan engine handles one request at a time and takes no new
//    one until the last is done; a two-deep request queue keeps the input
//    open while a sample is scanned, until the queue is full.
//  - Reset (rst_n low, synchronous) clears all latches, the queue, the active
//    count and the output; table contents stay undefined until written.
//  - When the receiver stalls, the result waits in the output register; the scan
//    engine may start the next request but holds its result until that register is free; the queue still fills.
module region_entry_trigger_table
  import rtt_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_region_index,
  input  logic               in_region_kind,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  input  logic signed [23:0] in_coord_z,
  input  logic signed [23:0] in_end_x,
  input  logic signed [23:0] in_end_y,
  input  logic [22:0]        in_reach,
  input  logic [22:0]        in_slab_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_fired,
  output logic [3:0]         out_fired_region
);

  // number of entries scanned, from index zero
  logic [4:0] active_regions_r;
  logic       q_valid;
  logic       q_pop;
  rtt_req_t   q_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_regions_r <= '0;
    end else if (cfg_wr_en) begin
      active_regions_r <= cfg_wr_data;
    end
  end

  // front: accept and decode requests into the queue
  rtt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_region_index (in_region_index),
    .in_region_kind  (in_region_kind),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_reach        (in_reach),
    .in_slab_height  (in_slab_height),
    .q_valid         (q_valid),
    .q_req           (q_req),
    .q_pop           (q_pop)
  );

  // back: table, latches, scan and result register
  rtt_scan #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .active_regions   (active_regions_r),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fired        (out_fired),
    .out_fired_region (out_fired_region)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for region_entry_trigger_table.
// Random and directed requests against an in-bench copy of the trigger table;
// depends on rtl/rtt_pkg.sv and rtl/region_entry_trigger_table.sv (with rtl/rtt_front.sv and rtl/rtt_scan.sv).
module testbench;
  import rtt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    rtt_op_t            op;
    logic [3:0]         idx;
    logic               kind;
    logic signed [23:0] x, y, z, ex, ey;
    logic [22:0]        reach, height;
  } req_t;

  typedef struct {
    logic       fired;
    logic [3:0] region;
  } trig_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [4:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [3:0] in_region_index = '0;
  logic in_region_kind = 0;
  logic signed [23:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic signed [23:0] in_end_x = '0, in_end_y = '0;
  logic [22:0] in_reach = '0, in_slab_height = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_fired;
  logic [3:0] out_fired_region;

  region_entry_trigger_table #(.MAX_REGIONS(NREG)) dut (.*);

  always #5 clk = ~clk;

  // Table copy as the block sees it (updated on request acceptance).
  logic               tab_kind [NREG];
  logic signed [23:0] tab_x [NREG], tab_y [NREG], tab_z [NREG];
  logic signed [23:0] tab_ex [NREG], tab_ey [NREG];
  logic [22:0]        tab_r [NREG], tab_h [NREG];
  logic [NREG-1:0]    latch_bits = '0;
  int                 scan_count = 0;

  // Generator-side shadow, used only to aim samples at regions.
  req_t               plan [NREG];

  req_t  pending_q[$];
  trig_t trig_q[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    bursty = 1;
  int    in_gap = 0;
  int    out_gap = 0;

  // Gap length: mostly none or short, now and then long; none in quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!bursty || r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit sphere_hit(int i, longint px, longint py, longint pz);
    longint dx, dy, dz, r;
    dx = longint'(tab_x[i]) - px;
    dy = longint'(tab_y[i]) - py;
    dz = longint'(tab_z[i]) - pz;
    r = longint'(tab_r[i]);
    return dx * dx + dy * dy + dz * dz < r * r;
  endfunction

  function automatic bit slab_hit(int i, longint px, longint py, longint pz);
    longint base, e1x, e1y, e2x, e2y, d, t, cr, r;
    logic [127:0] lhs, rhs;
    base = tab_z[i];
    if (!(pz > base && pz < base + longint'(tab_h[i]))) return 0;
    e1x = longint'(tab_ex[i]) - longint'(tab_x[i]);
    e1y = longint'(tab_ey[i]) - longint'(tab_y[i]);
    e2x = px - longint'(tab_x[i]);
    e2y = py - longint'(tab_y[i]);
    d = e1x * e1x + e1y * e1y;
    if (d == 0) return 0;  // degenerate segment never triggers
    t = e1x * e2x + e1y * e2y;
    if (t < 0 || t > d) return 0;
    cr = e1x * e2y - e1y * e2x;
    if (cr < 0) cr = -cr;
    r = longint'(tab_r[i]);
    lhs = 128'(cr) * 128'(cr);
    rhs = 128'(r * r) * 128'(d);
    return lhs < rhs;
  endfunction

  // Apply one accepted request to the table copy and queue its result.
  function automatic void apply_request(req_t q);
    trig_t res;
    int n;
    res = '{fired: 1'b0, region: 4'd0};
    case (q.op)
      OP_WRITE: begin
        tab_kind[q.idx] = q.kind;
        tab_x[q.idx] = q.x;
        tab_y[q.idx] = q.y;
        tab_z[q.idx] = q.z;
        tab_ex[q.idx] = q.ex;
        tab_ey[q.idx] = q.ey;
        tab_r[q.idx] = q.reach;
        tab_h[q.idx] = q.height;
        latch_bits[q.idx] = 1'b0;
      end
      OP_CLEAR: latch_bits = '0;
      OP_SAMPLE: begin
        n = scan_count > NREG ? NREG : scan_count;
        for (int i = 0; i < n; i++) begin
          if (!latch_bits[i] &&
              ((tab_kind[i] == KIND_SLAB) ? slab_hit(i, q.x, q.y, q.z)
                                          : sphere_hit(i, q.x, q.y, q.z))) begin
            latch_bits[i] = 1'b1;
            res = '{fired: 1'b1, region: 4'(i)};
            break;
          end
        end
      end
      default: ;
    endcase
    trig_q.insert(trig_q.size(), res);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    req_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request('{op: rtt_op_t'(in_operation), idx: in_region_index,
                        kind: in_region_kind, x: in_coord_x, y: in_coord_y,
                        z: in_coord_z, ex: in_end_x, ey: in_end_y,
                        reach: in_reach, height: in_slab_height});
        in_gap = pick_gap();
        if ($urandom_range(0, 149) == 0) bursty = !bursty;
      end
      if (in_valid && !in_ready) begin
        // hold the request until it is taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        q = pending_q.pop_front();
        in_operation <= q.op;
        in_region_index <= q.idx;
        in_region_kind <= q.kind;
        in_coord_x <= q.x;
        in_coord_y <= q.y;
        in_coord_z <= q.z;
        in_end_x <= q.ex;
        in_end_y <= q.ey;
        in_reach <= q.reach;
        in_slab_height <= q.height;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor, receiver stalls and watchdog.
  always @(posedge clk) begin
    trig_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (trig_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result fired=%0d region=%0d", out_fired, out_fired_region);
        end else begin
          want = trig_q.pop_front();
          if (out_fired !== want.fired || out_fired_region !== want.region) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected fired=%0d region=%0d, got fired=%0d region=%0d",
                       want.fired, want.region, out_fired, out_fired_region);
          end
        end
        out_gap = pick_gap();
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[region_entry_trigger_table] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [23:0] near(longint c, longint span);
    return 24'(c + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic req_t blank_req(rtt_op_t op);
    req_t q;
    q = '{op: op, idx: 4'($urandom), kind: 1'($urandom), x: 24'($urandom),
          y: 24'($urandom), z: 24'($urandom), ex: 24'($urandom), ey: 24'($urandom),
          reach: 23'($urandom), height: 23'($urandom)};
    return q;
  endfunction

  // Append one request to the driver's pending list.
  function automatic void enqueue(req_t q);
    pending_q.insert(pending_q.size(), q);
  endfunction

  function automatic void push_write(req_t q);
    plan[q.idx] = q;
    enqueue(q);
  endfunction

  // Random region: mostly compact and near the origin so samples can hit it.
  function automatic req_t rand_region();
    req_t q;
    q = blank_req(OP_WRITE);
    if ($urandom_range(0, 9) != 0) begin
      q.x = near(0, 4096);
      q.y = near(0, 4096);
      q.z = near(0, 4096);
      q.ex = near(q.x, 2048);
      q.ey = near(q.y, 2048);
      q.reach = 23'($urandom_range(0, 1024));
      q.height = 23'($urandom_range(0, 4096));
      if ($urandom_range(0, 11) == 0) begin
        q.ex = q.x;   // degenerate segment
        q.ey = q.y;
      end
    end
    return q;
  endfunction

  // Sample aimed at one planned region, sometimes just outside it.
  function automatic req_t aimed_sample(int lim);
    req_t q, g;
    longint r, k;
    q = blank_req(OP_SAMPLE);
    g = plan[$urandom_range(0, lim - 1)];
    r = longint'(g.reach) + 2;
    if (g.kind == KIND_SPHERE) begin
      q.x = near(g.x, r);
      q.y = near(g.y, r);
      q.z = near(g.z, r);
    end else begin
      k = $urandom_range(0, 8);
      q.x = near(g.x + (longint'(g.ex) - g.x) * k / 8, r);
      q.y = near(g.y + (longint'(g.ey) - g.y) * k / 8, r);
      q.z = 24'(longint'(g.z) + $urandom_range(0, g.height + 1));
    end
    return q;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || trig_q.size() > 0) @(posedge clk);
  endtask

  task automatic set_scan_count(int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 5'(v);
    scan_count = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int phases[8];
    req_t q;
    int sel, lim;

    phases = '{16, 1, 0, 31, 17, 8, 16, 5};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: fill every entry (extremes, degenerate slab, zero reach),
    // then clear, unused code and a few extreme samples.
    set_scan_count(0);
    for (int i = 0; i < NREG; i++) begin
      q = rand_region();
      q.idx = 4'(i);
      case (i)
        0: begin q.kind = KIND_SPHERE; q.x = 24'sh7FFFFF; q.y = 24'sh800000;
                 q.z = 24'sh7FFFFF; q.reach = 23'h7FFFFF; end
        1: begin q.kind = KIND_SLAB; q.x = 24'sh800000; q.y = 24'sh7FFFFF;
                 q.ex = 24'sh7FFFFF; q.ey = 24'sh800000; q.z = 24'sh800000;
                 q.reach = 23'h7FFFFF; q.height = 23'h7FFFFF; end
        2: begin q.kind = KIND_SLAB; q.ex = q.x; q.ey = q.y; end
        3: begin q.kind = KIND_SPHERE; q.reach = '0; end
        default: ;
      endcase
      push_write(q);
    end
    enqueue(blank_req(OP_CLEAR));
    enqueue(blank_req(OP_NOP));
    q = blank_req(OP_SAMPLE);
    q.x = 24'sh800000; q.y = 24'sh800000; q.z = 24'sh800000;
    enqueue(q);
    q.x = 24'sh7FFFFF; q.y = 24'sh7FFFFF; q.z = 24'sh7FFFFF;
    enqueue(q);
    wait_idle();

    foreach (phases[p]) begin
      set_scan_count(phases[p]);
      if (p == 1) begin
        // full-range corner sample, then a clear; only entry 0 is scanned
        q = blank_req(OP_SAMPLE);
        q.x = 24'sh7FFFFF; q.y = 24'sh800000; q.z = 24'sh7FFFFF;
        enqueue(q);
        enqueue(blank_req(OP_CLEAR));
      end
      lim = phases[p] == 0 ? NREG : (phases[p] > NREG ? NREG : phases[p]);
      for (int n = 0; n < 105; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 58) enqueue(aimed_sample(lim));
        else if (sel < 72) enqueue(blank_req(OP_SAMPLE));
        else if (sel < 88) push_write(rand_region());
        else if (sel < 95) enqueue(blank_req(OP_CLEAR));
        else enqueue(blank_req(OP_NOP));
      end
      wait_idle();
    end

    repeat (400) @(posedge clk);
    if (mismatches == 0 && trig_q.size() == 0) begin
      $display("[region_entry_trigger_table] OK");
    end else begin
      $display("[region_entry_trigger_table] ERROR");
    end
    $finish;
  end

endmodule
